// ===== design/jts_pkg.sv =====
// Shared types and constants for the joint target smoother.
// Holds field widths, beat layouts, controller states and datapath commands.
package jts_pkg;

  localparam int JOINTS     = 7;
  localparam int FRAC_BITS  = 16;
  localparam int POS_BITS   = 20;
  localparam int COEF_BITS  = FRAC_BITS + 1;
  localparam int JIDX_BITS  = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  localparam int KIND_BITS  = 2;
  localparam int SEL_BITS   = 3;
  localparam int COUNT_BITS = 4;
  localparam int STAT_BITS  = 3;
  localparam int CFG_IDX_BITS = 2;

  // Input beat: joint_select, mode flag, value_count, then one position per joint.
  localparam int IN_MODE_LSB   = SEL_BITS;
  localparam int IN_COUNT_LSB  = IN_MODE_LSB + 1;
  localparam int IN_VAL_LSB    = IN_COUNT_LSB + COUNT_BITS;
  localparam int IN_FIELD_BITS = IN_VAL_LSB + JOINTS * POS_BITS;
  localparam int IN_TDATA_BITS = ((IN_FIELD_BITS + 7) / 8) * 8;

  localparam int OUT_FIELD_BITS = JOINTS * POS_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // Shared multiplier: coefficient operand times a difference or the filter scale.
  localparam int MUL_A_BITS    = COEF_BITS + 1;
  localparam int MUL_B_BITS    = POS_BITS + 2;
  localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;
  localparam int COEF_SUM_BITS = COEF_BITS + 2;

  localparam logic [COEF_BITS-1:0] COEF_ONE          = COEF_BITS'(1 << FRAC_BITS);
  localparam logic [COEF_BITS-1:0] FILTER_TARGET_RST = COEF_BITS'(6554);
  localparam logic [COEF_BITS-1:0] FILTER_SCALE_RST  = COEF_BITS'(1 << FRAC_BITS);
  localparam logic [COEF_BITS-1:0] CHANGE_RATE_RST   = COEF_BITS'(6554);

  localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_TARGET = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_SCALE  = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHANGE_RATE   = CFG_IDX_BITS'(2);

  typedef logic signed [POS_BITS-1:0] pos_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_START,
    KIND_TICK,
    KIND_CMD,
    KIND_LIMIT
  } kind_t;

  typedef enum logic [STAT_BITS-1:0] {
    STAT_DONE,
    STAT_ACCEPTED,
    STAT_BAD_COUNT,
    STAT_BEYOND,
    STAT_IGNORED
  } stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_START,
    ST_TICK,
    ST_F_SET,
    ST_J_DIFF,
    ST_J_MUL,
    ST_J_UPD,
    ST_C_DIFF,
    ST_C_MUL,
    ST_C_UPD,
    ST_CMD,
    ST_LIMIT,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_START,
    OP_TICK,
    OP_F_SET,
    OP_J_DIFF,
    OP_J_MUL,
    OP_J_UPD,
    OP_C_DIFF,
    OP_C_MUL,
    OP_C_UPD,
    OP_CMD,
    OP_LIMIT,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t                op;
    logic [JIDX_BITS-1:0]  jnt;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
  } dp_sts_t;

endpackage

// ===== design/jts_datapath.sv =====
// Datapath of the joint target smoother: joint stores, limit table, config
// registers, shared multiplier with rounding, and the output beat register.
// Depends on jts_pkg; driven by commands from jts_ctrl.
module jts_datapath import jts_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  dp_cmd_t                     cmd,
  output dp_sts_t                     sts,
  input  logic [IN_TDATA_BITS-1:0]    s_tdata,
  input  logic [KIND_BITS-1:0]        s_tuser,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [COEF_BITS-1:0]        cfg_data,
  output logic [OUT_TDATA_BITS-1:0]   m_tdata,
  output logic [STAT_BITS-1:0]        m_tuser
);

  function automatic logic [COEF_BITS-1:0] sat_coef(input logic [COEF_BITS-1:0] v);
    return (v > COEF_ONE) ? COEF_ONE : v;
  endfunction

  logic [COEF_BITS-1:0] filter_target;
  logic [COEF_BITS-1:0] filter_scale;
  logic [COEF_BITS-1:0] change_rate;
  logic [COEF_BITS-1:0] coef_state;

  pos_t command_pos  [JOINTS];
  pos_t target_pos   [JOINTS];
  pos_t measured_pos [JOINTS];
  pos_t lower_limits [JOINTS];
  pos_t upper_limits [JOINTS];

  kind_t                 in_kind;
  logic [SEL_BITS-1:0]   in_sel;
  logic                  in_pmode;
  logic [COUNT_BITS-1:0] in_count;
  pos_t                  in_val [JOINTS];

  logic        [COEF_BITS-1:0]  f_r;
  logic signed [MUL_B_BITS-1:0] diff_r;
  logic signed [PROD_BITS-1:0]  prod;
  stat_t                        status_r;
  pos_t                         res_cmd [JOINTS];
  stat_t                        out_status;
  pos_t                         out_cmd [JOINTS];

  logic signed [MUL_A_BITS-1:0]    mul_a;
  logic signed [MUL_B_BITS-1:0]    mul_b;
  logic signed [PROD_BITS-1:0]     rnd_sum;
  logic signed [PROD_BITS-1:0]     rnd_val;
  logic signed [COEF_SUM_BITS-1:0] coef_sum;
  logic        [COEF_BITS-1:0]     coef_next;
  logic        [JOINTS-1:0]        beyond;
  stat_t                           cmd_status;

  localparam logic signed [PROD_BITS-1:0] RND_HALF = PROD_BITS'(1 << (FRAC_BITS - 1));
  localparam pos_t POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam pos_t POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

  assign sts.kind = in_kind;

  // Operand select for the one multiplier.
  always_comb begin
    unique case (cmd.op)
      OP_TICK: begin
        mul_a = MUL_A_BITS'(coef_state);
        mul_b = MUL_B_BITS'(filter_scale);
      end
      OP_C_MUL: begin
        mul_a = MUL_A_BITS'(change_rate);
        mul_b = diff_r;
      end
      default: begin
        mul_a = MUL_A_BITS'(f_r);
        mul_b = diff_r;
      end
    endcase
  end

  // Round to nearest, ties toward plus infinity.
  always_comb begin
    rnd_sum  = prod + RND_HALF;
    rnd_val  = rnd_sum >>> FRAC_BITS;
    coef_sum = COEF_SUM_BITS'(coef_state) + rnd_val[COEF_SUM_BITS-1:0];
    if (coef_sum < 0) begin
      coef_next = '0;
    end else if (coef_sum > COEF_SUM_BITS'(COEF_ONE)) begin
      coef_next = COEF_ONE;
    end else begin
      coef_next = coef_sum[COEF_BITS-1:0];
    end
  end

  always_comb begin
    for (int j = 0; j < JOINTS; j++) begin
      beyond[j] = (in_val[j] < lower_limits[j]) || (in_val[j] > upper_limits[j]);
    end
    priority if (!in_pmode) begin
      cmd_status = STAT_IGNORED;
    end else if (in_count != COUNT_BITS'(JOINTS)) begin
      cmd_status = STAT_BAD_COUNT;
    end else if (|beyond) begin
      cmd_status = STAT_BEYOND;
    end else begin
      cmd_status = STAT_ACCEPTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_target <= FILTER_TARGET_RST;
      filter_scale  <= FILTER_SCALE_RST;
      change_rate   <= CHANGE_RATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILTER_TARGET: filter_target <= sat_coef(cfg_data);
        CFG_FILTER_SCALE:  filter_scale  <= sat_coef(cfg_data);
        CFG_CHANGE_RATE:   change_rate   <= sat_coef(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_state <= '0;
      for (int j = 0; j < JOINTS; j++) begin
        command_pos[j]  <= '0;
        target_pos[j]   <= '0;
        measured_pos[j] <= '0;
        lower_limits[j] <= POS_MIN;
        upper_limits[j] <= POS_MAX;
      end
    end else begin
      unique case (cmd.op)
        OP_START: begin
          for (int j = 0; j < JOINTS; j++) begin
            command_pos[j]  <= in_val[j];
            target_pos[j]   <= in_val[j];
            measured_pos[j] <= in_val[j];
          end
        end
        OP_TICK: begin
          for (int j = 0; j < JOINTS; j++) begin
            measured_pos[j] <= in_val[j];
          end
        end
        OP_J_UPD: begin
          command_pos[cmd.jnt] <= command_pos[cmd.jnt] + rnd_val[POS_BITS-1:0];
        end
        OP_C_UPD: coef_state <= coef_next;
        OP_CMD: begin
          if (cmd_status == STAT_ACCEPTED) begin
            for (int j = 0; j < JOINTS; j++) begin
              target_pos[j] <= in_val[j];
            end
          end else if (cmd_status == STAT_BAD_COUNT || cmd_status == STAT_BEYOND) begin
            // fall back to the last measured positions
            for (int j = 0; j < JOINTS; j++) begin
              command_pos[j] <= measured_pos[j];
              target_pos[j]  <= measured_pos[j];
            end
          end
        end
        OP_LIMIT: begin
          if (int'(in_sel) < JOINTS) begin
            lower_limits[in_sel[JIDX_BITS-1:0]] <= in_val[0];
            upper_limits[in_sel[JIDX_BITS-1:0]] <= in_val[1];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE: begin
        in_kind  <= kind_t'(s_tuser);
        in_sel   <= s_tdata[SEL_BITS-1:0];
        in_pmode <= s_tdata[IN_MODE_LSB];
        in_count <= s_tdata[IN_COUNT_LSB +: COUNT_BITS];
        for (int j = 0; j < JOINTS; j++) begin
          in_val[j]  <= s_tdata[IN_VAL_LSB + j*POS_BITS +: POS_BITS];
          res_cmd[j] <= '0;
        end
        status_r <= STAT_DONE;
      end
      OP_TICK: begin
        // report the commands as they stand before this tick moves them
        for (int j = 0; j < JOINTS; j++) begin
          res_cmd[j] <= command_pos[j];
        end
        prod <= mul_a * mul_b;
      end
      OP_F_SET:  f_r <= prod[FRAC_BITS +: COEF_BITS];
      OP_J_DIFF: diff_r <= MUL_B_BITS'(target_pos[cmd.jnt]) - MUL_B_BITS'(command_pos[cmd.jnt]);
      OP_J_MUL:  prod <= mul_a * mul_b;
      OP_C_DIFF: diff_r <= MUL_B_BITS'(filter_target) - MUL_B_BITS'(coef_state);
      OP_C_MUL:  prod <= mul_a * mul_b;
      OP_CMD:    status_r <= cmd_status;
      OP_EMIT: begin
        out_status <= status_r;
        for (int j = 0; j < JOINTS; j++) begin
          out_cmd[j] <= res_cmd[j];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    m_tdata = '0;
    for (int j = 0; j < JOINTS; j++) begin
      m_tdata[j*POS_BITS +: POS_BITS] = out_cmd[j];
    end
  end

  assign m_tuser = out_status;

endmodule

// ===== design/jts_ctrl.sv =====
// Controller of the joint target smoother (jts_pkg): sequences each item
// through the datapath one step a cycle unless held; owns both handshakes.
module jts_ctrl import jts_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t               state;
  state_t               state_next;
  logic [JIDX_BITS-1:0] jnt;
  logic                 jnt_last;
  logic                 emit_go;

  assign jnt_last = (jnt == JIDX_BITS'(JOINTS - 1));
  // The output register is free, or its beat leaves this cycle.
  assign emit_go  = (state == ST_EMIT) && (!m_tvalid || m_tready);
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_DECODE;
      ST_DECODE: begin
        unique case (sts.kind)
          KIND_START: state_next = ST_START;
          KIND_TICK:  state_next = ST_TICK;
          KIND_CMD:   state_next = ST_CMD;
          KIND_LIMIT: state_next = ST_LIMIT;
          default:    state_next = ST_EMIT;
        endcase
      end
      ST_START:  state_next = ST_EMIT;
      ST_TICK:   state_next = ST_F_SET;
      ST_F_SET:  state_next = ST_J_DIFF;
      ST_J_DIFF: state_next = ST_J_MUL;
      ST_J_MUL:  state_next = ST_J_UPD;
      ST_J_UPD:  state_next = jnt_last ? ST_C_DIFF : ST_J_DIFF;
      ST_C_DIFF: state_next = ST_C_MUL;
      ST_C_MUL:  state_next = ST_C_UPD;
      ST_C_UPD:  state_next = ST_EMIT;
      ST_CMD:    state_next = ST_EMIT;
      ST_LIMIT:  state_next = ST_EMIT;
      ST_EMIT:   if (emit_go) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.jnt = jnt;
    unique case (state)
      ST_IDLE:   cmd.op = s_tvalid ? OP_CAPTURE : OP_NOP;
      ST_START:  cmd.op = OP_START;
      ST_TICK:   cmd.op = OP_TICK;
      ST_F_SET:  cmd.op = OP_F_SET;
      ST_J_DIFF: cmd.op = OP_J_DIFF;
      ST_J_MUL:  cmd.op = OP_J_MUL;
      ST_J_UPD:  cmd.op = OP_J_UPD;
      ST_C_DIFF: cmd.op = OP_C_DIFF;
      ST_C_MUL:  cmd.op = OP_C_MUL;
      ST_C_UPD:  cmd.op = OP_C_UPD;
      ST_CMD:    cmd.op = OP_CMD;
      ST_LIMIT:  cmd.op = OP_LIMIT;
      ST_EMIT:   cmd.op = emit_go ? OP_EMIT : OP_NOP;
      default:   cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      jnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_J_UPD) begin
        jnt <= jnt_last ? '0 : jnt + 1'b1;
      end
      if (emit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_DECODE))
    else $error("accepted beat not decoded next cycle");

  a_joint_sweep_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_J_UPD && jnt_last) |=> (state == ST_C_DIFF && jnt == '0))
    else $error("joint sweep did not finish cleanly");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> (m_tvalid && state == ST_IDLE))
    else $error("emitted result not presented");
`endif

endmodule

// ===== design/joint_target_smoother.sv =====
// Seven-joint position command smoother with a first-order command filter.
// Tick item: the single shared multiplier steps through a filter step, then
// a difference, multiply and update step for each of the seven joints, then
// the coefficient update; other items one action step. Items do not overlap.
// Synchronous active-high rst clears stores to zero, limits to full range,
// and config to defaults; no clearing pass.
module joint_target_smoother import jts_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // joint_select, mode flag, value_count, val0..val6, zero pad
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,
  // kind
  input  logic [KIND_BITS-1:0]      s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // cmd0..cmd6, zero pad
  output logic [OUT_TDATA_BITS-1:0] m_tdata,
  // status
  output logic [STAT_BITS-1:0]      m_tuser,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [COEF_BITS-1:0]      cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  jts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jts_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
